FILE: hdl/rdf_pkg.sv
package rdf_pkg;

  // Default width of the value field.
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Digit store and digit counter sizes.
  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned DIGIT_W     = 5;

  // Radix register.
  localparam int unsigned RADIX_W         = 5;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd20;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  // Character encoding.
  localparam int unsigned CHAR_W = 7;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 5'd10;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } rdf_state_e;

  // Requests from the sequencer to the divider.
  typedef struct packed {
    logic start;
    logic load;
  } rdf_div_ctrl_t;

  // Divider status back to the sequencer.
  typedef struct packed {
    logic done;
    logic nz;
  } rdf_div_stat_t;

  // Clamp the radix register into the supported range.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Map a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_DIGITS) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_UPPER + CHAR_W'(d - DEC_DIGITS);
    end
    return res;
  endfunction

endpackage

FILE: hdl/rdf_div_serial.sv
module rdf_div_serial #(
  parameter int unsigned VALUE_WIDTH = rdf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rdf_pkg::rdf_div_ctrl_t     ctrl_i,
  input  logic [VALUE_WIDTH-1:0]     value_i,
  input  logic [rdf_pkg::RADIX_W-1:0] base_i,
  output rdf_pkg::rdf_div_stat_t     stat_o,
  output logic [rdf_pkg::DIGIT_W-1:0] digit_o
);
  import rdf_pkg::*;

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] val_q;
  logic [DIGIT_W-1:0]     rem_q, rem_next;
  logic [CW-1:0]          cnt_q;
  logic                   active_q, done_q, nz_q;
  logic [DIGIT_W:0]       trial;
  logic                   ge;

  // One restoring division step: bring in the next dividend bit.
  always_comb begin
    trial = {rem_q, val_q[VALUE_WIDTH-1]};
    ge    = (trial >= {1'b0, base_i});
    if (ge) begin
      rem_next = DIGIT_W'(trial - {1'b0, base_i});
    end else begin
      rem_next = DIGIT_W'(trial);
    end
  end

  // Step counter and completion flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      nz_q     <= 1'b0;
      cnt_q    <= '0;
    end else if (ctrl_i.start) begin
      active_q <= 1'b1;
      done_q   <= 1'b0;
      nz_q     <= 1'b0;
      cnt_q    <= CW'(VALUE_WIDTH - 1);
    end else if (active_q) begin
      cnt_q <= cnt_q - 1'b1;
      nz_q  <= nz_q | ge;
      if (cnt_q == '0) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rem_q <= '0;
      if (ctrl_i.load) begin
        val_q <= value_i;
      end
    end else if (active_q) begin
      val_q <= {val_q[VALUE_WIDTH-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.nz   = nz_q;
  assign digit_o     = rem_q;

endmodule

FILE: hdl/radix_digit_formatter_unit.sv
// Radix digit formatter.
// Converts an unsigned value into its digit characters in a base from two to
// twenty, most significant first, with last_o on the final character.
// Input beat: value_i on in_valid_i/in_ready_o. Output beats: digit_char_o
// and last_o on out_valid_o/out_ready_i, one beat per digit. A value of zero
// is accepted and produces no beats.
// Configuration: cfg_radix_i on cfg_valid_i/cfg_ready_o; cfg_ready_o is
// always high. Radix values outside two to twenty are clamped. The radix is
// sampled when a value is accepted.
// Timing: digits are found by a bit-serial restoring divider, least
// significant first, and all of them are found before the first character
// appears; then one character per cycle follows while the receiver is ready.
// At most 32 digits are kept.
// A new value is accepted once the last character sits in the output
// register, even if it has not been taken yet.
// A stalled receiver holds the output register and the digit stack.
// Reset clears the sequencer, the output valid and sets the radix to ten.
module radix_digit_formatter_unit #(
  parameter int unsigned VALUE_WIDTH = rdf_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rdf_pkg::RADIX_W-1:0] cfg_radix_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [VALUE_WIDTH-1:0]      value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rdf_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                        last_o
);
  import rdf_pkg::*;

  rdf_state_e          state_q, state_d;
  logic [RADIX_W-1:0]  radix_q;
  logic [RADIX_W-1:0]  base_q;
  logic [COUNT_W-1:0]  count_q;
  logic [DIGIT_W-1:0]  stack_q [STORE_DEPTH];
  logic                out_valid_q;
  logic [CHAR_W-1:0]   char_q;
  logic                last_q;

  rdf_div_ctrl_t       div_ctrl;
  rdf_div_stat_t       div_stat;
  logic [DIGIT_W-1:0]  div_digit;

  logic in_acc, nonzero, more, push, pop, take_zero;

  assign nonzero = (value_i != '0);
  assign more    = div_stat.nz && (count_q != COUNT_W'(STORE_DEPTH - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && nonzero) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done && !more) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if ((!out_valid_q || out_ready_i) && (count_q == COUNT_W'(1))) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o    = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    div_ctrl      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        div_ctrl.load = in_valid_i && nonzero;
        div_ctrl.start = in_valid_i && nonzero;
      end
      S_DIV: begin
        push           = div_stat.done;
        div_ctrl.start = div_stat.done && more;
      end
      S_EMIT: begin
        pop = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign in_acc    = in_valid_i && in_ready_o;
  assign take_zero = in_acc && !nonzero;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radix_q     <= RADIX_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radix_q <= cfg_radix_i;
      end
      if (div_ctrl.load || take_zero) begin
        count_q <= '0;
      end else if (push) begin
        count_q <= count_q + 1'b1;
      end else if (pop) begin
        count_q <= count_q - 1'b1;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Digit stack: push at the bottom while dividing, pop from the bottom when
  // emitting, so the most significant digit leaves first.
  always_ff @(posedge clk_i) begin
    if (div_ctrl.load) begin
      base_q <= clamp_radix(radix_q);
    end
    if (push) begin
      stack_q[0] <= div_digit;
      for (int i = 1; i < STORE_DEPTH; i++) begin
        stack_q[i] <= stack_q[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < STORE_DEPTH - 1; i++) begin
        stack_q[i] <= stack_q[i+1];
      end
    end
    if (pop) begin
      char_q <= digit_to_char(stack_q[0]);
      last_q <= (count_q == COUNT_W'(1));
    end
  end

  // Bit-serial divider.
  rdf_div_serial #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (div_ctrl),
    .value_i (value_i),
    .base_i  (div_ctrl.load ? clamp_radix(radix_q) : base_q),
    .stat_o  (div_stat),
    .digit_o (div_digit)
  );

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_o       = last_q;

endmodule

FILE: hdl/rdf_checker.sv
module rdf_checker #(
  parameter int unsigned VALUE_WIDTH = rdf_pkg::VALUE_WIDTH_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o,
  input logic [rdf_pkg::RADIX_W-1:0] cfg_radix_i,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [VALUE_WIDTH-1:0]      value_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [rdf_pkg::CHAR_W-1:0]  digit_char_o,
  input logic                        last_o
);
  import rdf_pkg::*;

  // A stalled output beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digit_char_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  // Every character is a digit or one of the letters A to J.
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((digit_char_o >= 7'h30) && (digit_char_o <= 7'h39)) ||
                    ((digit_char_o >= 7'h41) && (digit_char_o <= 7'h4A)))
    else $error("character outside the digit set");

  // A nonzero value keeps the input closed while it is converted.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (value_i != '0) |=> !in_ready_o)
    else $error("input reopened right after a nonzero value");

  // While a character other than the last is pending, no new value is taken.
  a_no_accept_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input open in the middle of a run");

endmodule

bind radix_digit_formatter_unit rdf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_rdf_checker (.*);
